@@ src/gda_pkg.sv @@
package gda_pkg;

   localparam int ALU_W     = 16;
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int YACC_W    = 15;
   localparam int LEFT_W    = 16;
   localparam int REM_W     = 9;
   localparam int MOD_STEPS = 6;
   localparam int STEP_W    = 3;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YACC_W-1:0]  MAX_YEAR  = 15'd9999;
   localparam logic [ALU_W-1:0]   CYCLE_400 = 16'd400;
   localparam logic [REM_W-1:0]   REM_LAST  = 9'd399;
   localparam logic [REM_W-1:0]   REM_100   = 9'd100;
   localparam logic [REM_W-1:0]   REM_200   = 9'd200;
   localparam logic [REM_W-1:0]   REM_300   = 9'd300;

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [LEFT_W-1:0]  days_ahead;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
      logic               error;
   } rsp_type;

   // Leap test on the year taken modulo 400.
   function automatic logic is_leap(input logic [REM_W-1:0] rem);
      return (rem[1:0] == 2'b00) && (rem != REM_100) && (rem != REM_200)
             && (rem != REM_300);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ src/gda_alu.sv @@
module gda_alu (
   input  logic [gda_pkg::ALU_W-1:0] minuend,
   input  logic [gda_pkg::ALU_W-1:0] subtrahend,
   output logic [gda_pkg::ALU_W-1:0] difference,
   output logic                      no_borrow
);
   import gda_pkg::*;

   logic [ALU_W:0] full;

   assign full       = {1'b0, minuend} - {1'b0, subtrahend};
   assign difference = full[ALU_W-1:0];
   assign no_borrow  = ~full[ALU_W];

endmodule

@@ src/gregorian_date_advance.sv @@
// A valid start date is answered once the walk has crossed every month end that it needs; an
// invalid start date is answered with an error straight from the check state.
// The shared subtractor first reduces the year modulo 400 in six steps, then walks one month
// per cycle. One item at a time: busy stays high until the result cycle.
// Reset is synchronous and clears the sequencer, busy and the strobe; the receiver cannot stall.
module gregorian_date_advance (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gda_pkg::req_type  req_data,
   output logic              rsp_valid,
   output gda_pkg::rsp_type  rsp_data
);
   import gda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_WALK
   } state_type;

   state_type            state_ff, state_in;
   logic [DAY_W-1:0]     day_ff, day_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [YACC_W-1:0]    year_ff, year_in;
   logic [YACC_W-1:0]    yrem_ff, yrem_in;
   logic [LEFT_W-1:0]    left_ff, left_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
   logic                 alu_ok;
   logic                 leap;
   logic [DAY_W-1:0]     len;
   logic [DAY_W:0]       span;
   logic                 bad_date;

   gda_alu u_alu (
      .minuend    (alu_a),
      .subtrahend (alu_b),
      .difference (alu_diff),
      .no_borrow  (alu_ok)
   );

   assign leap = is_leap(yrem_ff[REM_W-1:0]);
   assign len  = month_len(month_ff, leap);
   // Days still left in this month, counting the move to the first of the next.
   assign span = {1'b0, len} + 6'd1 - {1'b0, day_ff};
   assign bad_date = (month_ff < MONTH_JAN) || (month_ff > MONTH_DEC) ||
                     (day_ff == '0) || (day_ff > len);

   always_comb begin
      if (state_ff == ST_MOD) begin
         alu_a = ALU_W'(yrem_ff);
         alu_b = CYCLE_400 << step_ff;
      end else begin
         alu_a = left_ff;
         alu_b = ALU_W'(span);
      end
   end

   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      yrem_in      = yrem_ff;
      left_in      = left_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               day_in   = req_data.start_day;
               month_in = req_data.start_month;
               year_in  = YACC_W'(req_data.start_year);
               yrem_in  = YACC_W'(req_data.start_year);
               left_in  = req_data.days_ahead;
               step_in  = STEP_W'(MOD_STEPS - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (alu_ok) begin
               yrem_in = alu_diff[YACC_W-1:0];
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bad_date) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{end_day: '0, end_month: '0, end_year: '0, error: 1'b1};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!alu_ok) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (year_ff > MAX_YEAR) begin
                  rsp_in = '{end_day: '0, end_month: '0, end_year: '0, error: 1'b1};
               end else begin
                  rsp_in = '{end_day:   day_ff + left_ff[DAY_W-1:0],
                             end_month: month_ff,
                             end_year:  year_ff[YEAR_W-1:0],
                             error:     1'b0};
               end
            end else begin
               left_in = alu_diff;
               day_in  = DAY_W'(1);
               if (month_ff == MONTH_DEC) begin
                  month_in = MONTH_JAN;
                  year_in  = year_ff + 1'b1;
                  yrem_in  = (yrem_ff[REM_W-1:0] == REM_LAST) ? '0 : yrem_ff + 1'b1;
               end else begin
                  month_in = month_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      yrem_ff  <= yrem_in;
      left_ff  <= left_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result is only given once the sequencer has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is busy");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |->
         (rsp_data.end_day == '0) && (rsp_data.end_month == '0) && (rsp_data.end_year == '0))
      else $error("error result carries a non-zero date");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("transfer did not start the sequencer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_valid_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.error |->
         (rsp_data.end_month >= MONTH_JAN) && (rsp_data.end_month <= MONTH_DEC)
         && (rsp_data.end_day != '0))
      else $error("good result with an impossible date");

endmodule
